[rtl/ttmp_pkg.sv]
// shared types and constants of the thermal task migration policy block
// no dependencies; every other file imports this package
package ttmp_pkg;

  // field widths
  localparam int CMD_W  = 2;
  localparam int CPU_W  = 3;
  localparam int POS_W  = CPU_W - 1;
  localparam int TEMP_W = 18;
  localparam int CNT_W  = 8;
  localparam int CD_W   = 4;
  localparam int ADDR_W = 2;

  // item commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  // configuration register indexes
  localparam logic [ADDR_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [ADDR_W-1:0] REG_MARGIN    = 2'd1;
  localparam logic [ADDR_W-1:0] REG_COOLDOWN  = 2'd2;

  // configuration reset values
  localparam logic [TEMP_W-1:0] THRESHOLD_RST = 18'd80000;
  localparam logic [TEMP_W-1:0] MARGIN_RST    = 18'd5000;
  localparam logic [CD_W-1:0]   COOLDOWN_RST  = 4'd10;

  // migrations per tick and count limit
  localparam int MAX_MOVES = 4;
  localparam int MOVES_W   = 3;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;

  typedef struct packed {
    logic [TEMP_W-1:0] threshold;
    logic [TEMP_W-1:0] margin;
    logic [CD_W-1:0]   cooldown;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              slot_ok;
    logic              cluster;
    logic [POS_W-1:0]  pos;
    logic [TEMP_W-1:0] temperature;
  } item_t;

  typedef struct packed {
    logic             migrated;
    logic [CPU_W-1:0] src_cpu;
    logic [CPU_W-1:0] to_cpu;
    logic             same_cluster;
    logic             last;
  } res_t;

endpackage

[rtl/ttmp_if.sv]
// channel interfaces: input items, result items, configuration writes
// depends on ttmp_pkg
interface ttmp_in_if import ttmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CPU_W-1:0]  cpu_number;
  logic [TEMP_W-1:0] temperature;

  modport source (output valid, cmd, cpu_number, temperature, input ready);
  modport sink (input valid, cmd, cpu_number, temperature, output ready);
endinterface

interface ttmp_out_if import ttmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             migrated;
  logic [CPU_W-1:0] src_cpu;
  logic [CPU_W-1:0] to_cpu;
  logic             same_cluster;
  logic             last;

  modport source (output valid, migrated, src_cpu, to_cpu, same_cluster, last,
                  input ready);
  modport sink (input valid, migrated, src_cpu, to_cpu, same_cluster, last,
                output ready);
endinterface

interface ttmp_cfg_if import ttmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] addr;
  logic [TEMP_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[rtl/ttmp_front.sv]
// front end: takes input items and maps the cpu number to cluster and slot
// depends on ttmp_pkg and ttmp_in_if
module ttmp_front import ttmp_pkg::*; #(
  parameter int CORES_PER_CLUSTER = 4
) (
  ttmp_in_if.sink in_ch,
  input  logic    push_ready,
  output logic    push_valid,
  output item_t   push_item
);

  logic [POS_W-1:0] half;

  // odd cpus live in cluster 0, even cpus in cluster 1
  assign half = in_ch.cpu_number[CPU_W-1:1];

  always_comb begin
    push_item.cmd         = in_ch.cmd;
    push_item.slot_ok     = (32'(half) < CORES_PER_CLUSTER);
    push_item.cluster     = ~in_ch.cpu_number[0];
    push_item.pos         = half;
    push_item.temperature = in_ch.temperature;
  end

  // item handshake into the queue
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

[rtl/ttmp_fifo.sv]
// short queue of classified items between front and back
// depends on ttmp_pkg
module ttmp_fifo import ttmp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_en,
  output item_t pop_item
);

  item_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_en && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/ttmp_back.sv]
// back end: per-slot state, tick scan sequencer, target search, result register
// depends on ttmp_pkg and ttmp_out_if
module ttmp_back import ttmp_pkg::*; #(
  parameter int CORES_PER_CLUSTER = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  q_pop,
  ttmp_out_if.source out_ch
);

  localparam int SLOTS  = 2 * CORES_PER_CLUSTER;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] CPC_S  = SLOT_W'(CORES_PER_CLUSTER);
  localparam logic [SLOT_W-1:0] LAST_S = SLOT_W'(SLOTS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic               side_r, side_nxt;
  logic [MOVES_W-1:0] moves_r, moves_nxt;
  logic [TEMP_W-1:0]  src_temp_r, src_temp_nxt;
  logic [TEMP_W-1:0]  temp_r [SLOTS];
  logic [TEMP_W-1:0]  temp_nxt [SLOTS];
  logic [CNT_W-1:0]   cnt_r [SLOTS];
  logic [CNT_W-1:0]   cnt_nxt [SLOTS];
  logic [CD_W-1:0]    cd_r [SLOTS];
  logic [CD_W-1:0]    cd_nxt [SLOTS];
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic                         out_free;
  logic                         emit;
  res_t                         emit_res;
  logic [SLOT_W-1:0]            item_slot;
  logic                         own_cl, srch_cl;
  logic                         is_src;
  logic [CORES_PER_CLUSTER-1:0] hit;
  logic                         hit_any;
  logic [SLOT_W-1:0]            hit_k;
  logic [SLOT_W-1:0]            tgt_slot;

  function automatic logic [CPU_W-1:0] slot_cpu(input logic [SLOT_W-1:0] s);
    logic              cl;
    logic [SLOT_W-1:0] pos;
    cl  = (s >= CPC_S);
    pos = cl ? s - CPC_S : s;
    return CPU_W'({pos, 1'b0}) | CPU_W'(!cl);
  endfunction

  assign out_free  = !out_valid_r || out_ch.ready;
  assign item_slot = q_item.cluster ? CPC_S + SLOT_W'(q_item.pos) : SLOT_W'(q_item.pos);

  // source test on the scanned slot
  assign own_cl  = (idx_r >= CPC_S);
  assign srch_cl = own_cl ^ side_r;
  assign is_src  = (cd_r[idx_r] == '0) && (cnt_r[idx_r] != '0) &&
                   (temp_r[idx_r] > cfg.threshold);

  // one cluster of candidate lanes per cycle, held while a found move waits for a free result register
  for (genvar k = 0; k < CORES_PER_CLUSTER; k++) begin : g_lane
    logic [CNT_W-1:0]  lane_cnt;
    logic [TEMP_W-1:0] lane_temp;
    assign lane_cnt  = srch_cl ? cnt_r[CORES_PER_CLUSTER + k] : cnt_r[k];
    assign lane_temp = srch_cl ? temp_r[CORES_PER_CLUSTER + k] : temp_r[k];
    assign hit[k]    = (lane_cnt == '0) &&
                       (({1'b0, lane_temp} + {1'b0, cfg.margin}) < {1'b0, src_temp_r});
  end

  // first hit wins
  always_comb begin
    hit_any = 1'b0;
    hit_k   = '0;
    for (int k = CORES_PER_CLUSTER - 1; k >= 0; k--) begin
      if (hit[k]) begin
        hit_any = 1'b1;
        hit_k   = SLOT_W'(k);
      end
    end
  end

  assign tgt_slot = srch_cl ? CPC_S + hit_k : hit_k;

  // sequencer and state updates
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    side_nxt     = side_r;
    moves_nxt    = moves_r;
    src_temp_nxt = src_temp_r;
    temp_nxt     = temp_r;
    cnt_nxt      = cnt_r;
    cd_nxt       = cd_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_res     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.cmd == CMD_TICK) begin
            q_pop = 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
              if (cd_r[s] != '0) begin
                cd_nxt[s] = cd_r[s] - 1'b1;
              end
            end
            idx_nxt   = '0;
            moves_nxt = '0;
            state_nxt = S_SCAN;
          end else if (out_free) begin
            q_pop         = 1'b1;
            emit          = 1'b1;
            emit_res.last = 1'b1;
            if (q_item.slot_ok) begin
              case (q_item.cmd)
                CMD_SAMPLE: temp_nxt[item_slot] = q_item.temperature;
                CMD_PLACE: begin
                  if (cnt_r[item_slot] != CNT_MAX) begin
                    cnt_nxt[item_slot] = cnt_r[item_slot] + 1'b1;
                  end
                end
                CMD_END: begin
                  if (cnt_r[item_slot] != '0) begin
                    cnt_nxt[item_slot] = cnt_r[item_slot] - 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      S_SCAN: begin
        if (is_src) begin
          src_temp_nxt = temp_r[idx_r];
          side_nxt     = 1'b0;
          state_nxt    = S_SRCH;
        end else if (idx_r == LAST_S) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SRCH: begin
        if (hit_any) begin
          if (out_free) begin
            emit                  = 1'b1;
            emit_res.migrated     = 1'b1;
            emit_res.src_cpu      = slot_cpu(idx_r);
            emit_res.to_cpu       = slot_cpu(tgt_slot);
            emit_res.same_cluster = !side_r;
            // target was idle, so it now holds exactly one task
            cnt_nxt[idx_r]        = cnt_r[idx_r] - 1'b1;
            cnt_nxt[tgt_slot]     = CNT_W'(1);
            cd_nxt[idx_r]         = cfg.cooldown;
            cd_nxt[tgt_slot]      = cfg.cooldown;
            moves_nxt             = moves_r + 1'b1;
            if (moves_r == MOVES_W'(MAX_MOVES - 1) || idx_r == LAST_S) begin
              state_nxt = S_DONE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_SCAN;
            end
          end
        end else if (!side_r) begin
          side_nxt = 1'b1;
        end else if (idx_r == LAST_S) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = emit_res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      side_r      <= 1'b0;
      moves_r     <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        temp_r[s] <= '0;
        cnt_r[s]  <= '0;
        cd_r[s]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      side_r      <= side_nxt;
      moves_r     <= moves_nxt;
      out_valid_r <= out_valid_nxt;
      temp_r      <= temp_nxt;
      cnt_r       <= cnt_nxt;
      cd_r        <= cd_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_temp_r <= src_temp_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.migrated     = out_res_r.migrated;
  assign out_ch.src_cpu      = out_res_r.src_cpu;
  assign out_ch.to_cpu       = out_res_r.to_cpu;
  assign out_ch.same_cluster = out_res_r.same_cluster;
  assign out_ch.last         = out_res_r.last;

  // checks
  a_moves_bound: assert property (@(posedge clk) disable iff (!rst_n)
    moves_r <= MOVES_W'(MAX_MOVES))
    else $error("more migrations than allowed in one tick");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_mig_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && hit_any && out_free) |=> out_valid_r && out_res_r.migrated)
    else $error("migration not presented on the result register");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_res.last) |=> state_r == S_IDLE)
    else $error("sequencer busy after the final result of an item");

endmodule

[rtl/thermal_task_migration_policy.sv]
// Channel  Dir  Handshake               Payload
// in_ch    in   valid/ready             cmd, cpu_number, temperature
// out_ch   out  valid/ready             migrated, src_cpu, to_cpu, same_cluster, last
// cfg_ch   in   valid/ready (ready = 1) addr, data
//
// a sample, place or end item is queued, then registered in the back end's result register
// a tick is run by the scan sequencer: each slot is scanned, a source slot searches its
// own cluster, then the other cluster; the end marker follows the last move or slot
// synchronous active-low reset clears all slot state and restores the configuration defaults
// a stalled result holds the back end when it must emit; the front fills a two-item queue
//
// top level: configuration registers, front end, queue and back end
// depends on ttmp_pkg, ttmp_if, ttmp_front, ttmp_fifo, ttmp_back
module thermal_task_migration_policy import ttmp_pkg::*; #(
  parameter int CORES_PER_CLUSTER = 4
) (
  input logic clk,
  input logic rst_n,
  ttmp_in_if.sink    in_ch,
  ttmp_out_if.source out_ch,
  ttmp_cfg_if.sink   cfg_ch
);

  cfg_t  cfg_r;
  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_en;
  item_t pop_item;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.margin    <= MARGIN_RST;
      cfg_r.cooldown  <= COOLDOWN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_THRESHOLD: cfg_r.threshold <= cfg_ch.data;
        REG_MARGIN:    cfg_r.margin    <= cfg_ch.data;
        REG_COOLDOWN:  cfg_r.cooldown  <= cfg_ch.data[CD_W-1:0];
        default: ;
      endcase
    end
  end

  // item classification
  ttmp_front #(
    .CORES_PER_CLUSTER(CORES_PER_CLUSTER)
  ) u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // decoupling queue
  ttmp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_item   (pop_item)
  );

  // slot state and migration scan
  ttmp_back #(
    .CORES_PER_CLUSTER(CORES_PER_CLUSTER)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop_en),
    .out_ch  (out_ch)
  );

endmodule

[sim/thermal_task_migration_policy_tb.sv]
// testbench for thermal_task_migration_policy: directed table, then random phases
// results are checked against marker rows or an in-file model of the balancer
// depends on ttmp_pkg, ttmp_if and the rtl top level
module thermal_task_migration_policy_tb;
  import ttmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORES       = 4;
  localparam int SLOTS       = 2 * CORES;
  localparam int TEMP_TOP    = 200000;
  localparam int DRAIN       = 30;
  localparam int QUIET_LIMIT = 2000;
  localparam int ROWS        = 26;
  localparam int PHASE_ITEMS = 46;

  localparam res_t END_MARK = '{migrated: 1'b0, src_cpu: '0, to_cpu: '0,
                                same_cluster: 1'b0, last: 1'b1};

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CMD_W-1:0]  cmd;
    logic [CPU_W-1:0]  cpu;
    logic [TEMP_W-1:0] temp;    // write data on register rows
    logic [ADDR_W-1:0] addr;
    logic              typed;
    res_t              want;
  } row_t;

  logic clk;
  logic rst_n;

  ttmp_in_if  in_ch();
  ttmp_out_if out_ch();
  ttmp_cfg_if cfg_ch();

  thermal_task_migration_policy #(.CORES_PER_CLUSTER(CORES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // balancer model state
  logic [TEMP_W-1:0] thr_q;
  logic [TEMP_W-1:0] margin_q;
  logic [CD_W-1:0]   cd_ticks_q;
  logic [TEMP_W-1:0] core_temp [SLOTS];
  logic [CNT_W-1:0]  tasks     [SLOTS];
  logic [CD_W-1:0]   hold_off  [SLOTS];

  res_t step_out    [$];
  res_t due_results [$];

  int fails;
  int quiet;
  int in_gap_pct;
  int out_stall_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // os cpu number to slot: odd cpus in cluster 0, even in cluster 1
  function automatic int slot_of(logic [CPU_W-1:0] cpu);
    if (int'(cpu >> 1) >= CORES) return -1;
    if (cpu[0]) return int'(cpu >> 1);
    return int'(cpu >> 1) + CORES;
  endfunction

  function automatic logic [CPU_W-1:0] cpu_of(int slot);
    if (slot < CORES) return CPU_W'(slot * 2 + 1);
    return CPU_W'((slot - CORES) * 2);
  endfunction

  // first idle slot of a cluster cooler than the source by more than the margin
  function automatic int find_target(int cluster, int src);
    int base;
    base = cluster * CORES;
    for (int k = base; k < base + CORES; k++) begin
      if (k != src && tasks[k] == '0 &&
          int'(core_temp[k]) + int'(margin_q) < int'(core_temp[src]))
        return k;
    end
    return -1;
  endfunction

  // advance the model by one item, results land in step_out
  task automatic predict_balance(input logic [CMD_W-1:0] cmd, input logic [CPU_W-1:0] cpu,
                                 input logic [TEMP_W-1:0] temp);
    int   s;
    int   tgt;
    int   moves;
    logic same;
    step_out.delete();
    s = slot_of(cpu);
    if (cmd != CMD_TICK) begin
      if (s >= 0) begin
        case (cmd)
          CMD_SAMPLE: core_temp[s] = temp;
          CMD_PLACE:  if (tasks[s] != CNT_MAX) tasks[s] = tasks[s] + 1'b1;
          default:    if (tasks[s] != '0) tasks[s] = tasks[s] - 1'b1;
        endcase
      end
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (hold_off[i] != '0) hold_off[i] = hold_off[i] - 1'b1;
      moves = 0;
      // scan in slot order, at most four moves per tick
      for (int i = 0; i < SLOTS && moves < MAX_MOVES; i++) begin
        if (hold_off[i] == '0 && tasks[i] != '0 && core_temp[i] > thr_q) begin
          same = 1'b1;
          tgt = find_target(i / CORES, i);
          if (tgt < 0) begin
            tgt = find_target(1 - i / CORES, i);
            same = 1'b0;
          end
          if (tgt >= 0) begin
            if (tasks[tgt] != CNT_MAX) tasks[tgt] = tasks[tgt] + 1'b1;
            tasks[i] = tasks[i] - 1'b1;
            hold_off[i] = cd_ticks_q;
            hold_off[tgt] = cd_ticks_q;
            step_out.push_back(res_t'{1'b1, cpu_of(i), cpu_of(tgt), same, 1'b0});
            moves++;
          end
        end
      end
    end
    step_out.push_back(END_MARK);
  endtask

  // table row builders
  function automatic row_t marker_row(logic [CMD_W-1:0] cmd, logic [CPU_W-1:0] cpu,
                                      logic [TEMP_W-1:0] temp);
    row_t r;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.cpu = cpu;
    r.temp = temp;
    r.addr = REG_THRESHOLD;
    r.typed = 1'b1;
    r.want = END_MARK;
    return r;
  endfunction

  function automatic row_t item_row(logic [CMD_W-1:0] cmd, logic [CPU_W-1:0] cpu,
                                    logic [TEMP_W-1:0] temp);
    row_t r;
    r = marker_row(cmd, cpu, temp);
    r.typed = 1'b0;
    return r;
  endfunction

  function automatic row_t reg_row(logic [ADDR_W-1:0] addr, logic [TEMP_W-1:0] value);
    row_t r;
    r = marker_row(CMD_SAMPLE, '0, value);
    r.kind = ROW_REG;
    r.addr = addr;
    r.typed = 1'b0;
    return r;
  endfunction

  // offer one item, record what it should cause once accepted
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CPU_W-1:0] cpu,
                           input logic [TEMP_W-1:0] temp, input logic typed,
                           input res_t want);
    if ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.cpu_number  <= cpu;
    in_ch.temperature <= temp;
    do @(posedge clk); while (!in_ch.ready);
    predict_balance(cmd, cpu, temp);
    if (typed) due_results.push_back(want);
    else foreach (step_out[k]) due_results.push_back(step_out[k]);
  endtask

  // register write, valid is left high for back-to-back writes
  task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [TEMP_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_THRESHOLD: thr_q = value;
      REG_MARGIN:    margin_q = value;
      REG_COOLDOWN:  cd_ticks_q = value[CD_W-1:0];
      default: ;
    endcase
  endtask

  // stop sending and wait for every pending result, then some quiet cycles
  task automatic settle(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic draw_item(output logic [CMD_W-1:0] cmd, output logic [CPU_W-1:0] cpu,
                           output logic [TEMP_W-1:0] temp);
    int pick;
    int sel;
    pick = $urandom_range(99);
    sel = $urandom_range(9);
    if (pick < 35)      cmd = CMD_SAMPLE;
    else if (pick < 60) cmd = CMD_PLACE;
    else if (pick < 75) cmd = CMD_END;
    else                cmd = CMD_TICK;
    cpu = CPU_W'($urandom_range(7));
    if (sel == 0)      temp = '0;
    else if (sel == 1) temp = TEMP_W'(TEMP_TOP);
    else               temp = TEMP_W'($urandom_range(TEMP_TOP));
  endtask

  // one random phase under its own register setting and idle mix
  task automatic run_phase(input logic [TEMP_W-1:0] thr, input logic [TEMP_W-1:0] margin,
                           input logic [CD_W-1:0] cd, input int in_pct, input int out_pct,
                           input int pause_at);
    logic [CMD_W-1:0]  cmd;
    logic [CPU_W-1:0]  cpu;
    logic [TEMP_W-1:0] temp;
    settle(DRAIN);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MARGIN, margin);
    write_reg(REG_COOLDOWN, TEMP_W'(cd));
    cfg_ch.valid <= 1'b0;
    in_gap_pct = in_pct;
    out_stall_pct = out_pct;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k == pause_at) settle(0);
      draw_item(cmd, cpu, temp);
      send_item(cmd, cpu, temp, 1'b0, END_MARK);
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // result checker
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{migrated: out_ch.migrated, src_cpu: out_ch.src_cpu, to_cpu: out_ch.to_cpu,
              same_cluster: out_ch.same_cluster, last: out_ch.last};
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: mig=%0d src=%0d to=%0d same=%0d last=%0d",
                   got.migrated, got.src_cpu, got.to_cpu, got.same_cluster, got.last);
      end else begin
        want = due_results.pop_front();
        if (got.migrated !== want.migrated || got.src_cpu !== want.src_cpu ||
            got.to_cpu !== want.to_cpu || got.same_cluster !== want.same_cluster ||
            got.last !== want.last) begin
          fails++;
          // fields in order: migrated, source cpu, target cpu, same cluster, last
          if (fails <= 10)
            $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     want.migrated, want.src_cpu, want.to_cpu, want.same_cluster,
                     want.last, got.migrated, got.src_cpu, got.to_cpu,
                     got.same_cluster, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // main sequence
  initial begin : stimulus
    row_t plan [ROWS];
    bit   reg_open;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_SAMPLE;
    in_ch.cpu_number  <= '0;
    in_ch.temperature <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.addr       <= REG_THRESHOLD;
    cfg_ch.data       <= '0;
    reg_open = 1'b0;
    thr_q = THRESHOLD_RST;
    margin_q = MARGIN_RST;
    cd_ticks_q = COOLDOWN_RST;
    for (int i = 0; i < SLOTS; i++) begin
      core_temp[i] = '0;
      tasks[i] = '0;
      hold_off[i] = '0;
    end
    in_gap_pct = 11;
    out_stall_pct = 62;

    plan = '{
      // reset setting: empty tick, end on an empty core, one same-cluster move
      marker_row(CMD_TICK,   3'd0, '0),
      marker_row(CMD_END,    3'd0, '0),
      marker_row(CMD_SAMPLE, 3'd0, TEMP_W'(TEMP_TOP)),
      marker_row(CMD_PLACE,  3'd0, '0),
      item_row(CMD_TICK,     3'd0, '0),
      // busy core exactly at the threshold is not a source
      marker_row(CMD_SAMPLE, 3'd6, TEMP_W'(80000)),
      marker_row(CMD_PLACE,  3'd6, '0),
      item_row(CMD_TICK,     3'd0, '0),
      // lowest setting: zero cooldown lets a fresh target move on in the same scan
      reg_row(REG_THRESHOLD, '0),
      reg_row(REG_MARGIN,    '0),
      reg_row(REG_COOLDOWN,  '0),
      marker_row(CMD_SAMPLE, 3'd1, TEMP_W'(TEMP_TOP)),
      marker_row(CMD_PLACE,  3'd1, '0),
      marker_row(CMD_SAMPLE, 3'd3, TEMP_W'(150000)),
      marker_row(CMD_SAMPLE, 3'd5, TEMP_W'(100000)),
      marker_row(CMD_SAMPLE, 3'd7, TEMP_W'(50000)),
      marker_row(CMD_END,    3'd2, '0),
      marker_row(CMD_SAMPLE, 3'd6, TEMP_W'(10000)),
      // chain of four moves ending in the other cluster, fifth source waits
      item_row(CMD_TICK,     3'd0, '0),
      item_row(CMD_TICK,     3'd0, '0),
      // highest setting
      reg_row(REG_THRESHOLD, TEMP_W'(TEMP_TOP)),
      reg_row(REG_MARGIN,    TEMP_W'(TEMP_TOP)),
      reg_row(REG_COOLDOWN,  TEMP_W'(15)),
      item_row(CMD_TICK,     3'd0, '0),
      marker_row(CMD_SAMPLE, 3'd2, '0),
      item_row(CMD_TICK,     3'd0, '0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < ROWS; r++) begin
      if (plan[r].kind == ROW_REG) begin
        if (!reg_open) settle(DRAIN);
        write_reg(plan[r].addr, plan[r].temp);
        reg_open = 1'b1;
      end else begin
        if (reg_open) cfg_ch.valid <= 1'b0;
        reg_open = 1'b0;
        send_item(plan[r].cmd, plan[r].cpu, plan[r].temp, plan[r].typed, plan[r].want);
      end
    end

    // random phases with varied settings and idle mixes
    run_phase(TEMP_W'(60000), TEMP_W'(3000), 4'd3, 11, 62, PHASE_ITEMS / 2);
    run_phase(TEMP_W'(40000), '0, '0, 62, 11, -1);
    run_phase(TEMP_W'($urandom_range(30000, 120000)), TEMP_W'($urandom_range(20000)),
              CD_W'($urandom_range(15)), 0, 0, -1);

    settle(DRAIN);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
